FILE: design/chained_hash_map_find_or_insert_top_assert.svh
// ----------------------------------------------------------------------------
// chained hash map assertion macros
// concurrent check wrappers that compile away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_FIND_OR_INSERT_TOP_ASSERT_SVH
`define CHAINED_HASH_MAP_FIND_OR_INSERT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication check
`define CHM_ASSERT_IMP(name, clock, rstn, pre, post) \
	name: assert property (@(posedge clock) disable iff (!rstn) (pre) |-> (post)) \
	else $error("chm implication check failed");

// next-cycle implication check
`define CHM_ASSERT_NXT(name, clock, rstn, pre, post) \
	name: assert property (@(posedge clock) disable iff (!rstn) (pre) |=> (post)) \
	else $error("chm next-cycle check failed");

`else

`define CHM_ASSERT_IMP(name, clock, rstn, pre, post)
`define CHM_ASSERT_NXT(name, clock, rstn, pre, post)

`endif

`endif

FILE: design/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// shared field widths, item structs and sequencer states of the hash map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chm_pkg;

	// fixed widths of the item fields
	localparam int KEY_FIELD_W   = 32;
	localparam int VALUE_FIELD_W = 32;
	localparam int COUNT_FIELD_W = 7;

	// key bits folded into the bucket remainder per cycle
	localparam int MOD_DIGIT_W = 4;

	typedef struct packed {
		logic                     action;
		logic [KEY_FIELD_W-1:0]   lookup_key;
		logic [VALUE_FIELD_W-1:0] write_data;
	} chm_req_t;

	typedef struct packed {
		logic [VALUE_FIELD_W-1:0] read_value;
		logic                     inserted;
		logic                     table_full;
		logic [COUNT_FIELD_W-1:0] entry_count;
		logic                     is_empty;
	} chm_rsp_t;

	// action codes
	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_WRITE  = 1'b1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_HASH  = 6'b000100,
		ST_HEAD  = 6'b001000,
		ST_NODE  = 6'b010000,
		ST_MISS  = 6'b100000
	} chm_state_t;

endpackage

FILE: design/chm_stream_if.sv
// ----------------------------------------------------------------------------
// chm_stream_if
// valid/ready stream channel carrying one payload struct per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/chm_bucket_mod.sv
// ----------------------------------------------------------------------------
// chm_bucket_mod
// key modulo bucket count: a mask for a power-of-two count, otherwise a
// remainder loop that folds a few key bits per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chm_bucket_mod
	import chm_pkg::*;
#(
	parameter int BUCKETS  = 16,
	parameter int KEY_BITS = 32,
	parameter int BW       = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_BITS-1:0] key,
	output logic                done,
	output logic [BW-1:0]       bucket
);

	localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

	generate
		if (IS_POW2) begin : g_mask
			logic          done_q;
			logic [BW-1:0] bucket_q;

			// low key bits select the bucket
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					bucket_q <= BW'(64'(key) & 64'(BUCKETS - 1));
				end
			end

			assign done   = done_q;
			assign bucket = bucket_q;
		end else begin : g_loop
			localparam int RW   = $clog2(BUCKETS) + 1;
			localparam int ND   = (KEY_BITS + MOD_DIGIT_W - 1) / MOD_DIGIT_W;
			localparam int PADW = ND * MOD_DIGIT_W;
			localparam int DCW  = $clog2(ND + 1);

			logic            busy_q;
			logic            done_q;
			logic [DCW-1:0]  dc_q;
			logic [PADW-1:0] sh_q;
			logic [RW-1:0]   rem_q;
			logic [RW-1:0]   rem_next;

			// shift in one digit, one compare and subtract per bit
			always_comb begin
				logic [RW-1:0] r;
				r = rem_q;
				for (int j = 0; j < MOD_DIGIT_W; j++) begin
					r = {r[RW-2:0], sh_q[PADW-1-j]};
					if (r >= RW'(BUCKETS)) begin
						r = r - RW'(BUCKETS);
					end
				end
				rem_next = r;
			end

			// digit counter and handshake
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					dc_q   <= '0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						busy_q <= 1'b1;
						dc_q   <= DCW'(ND);
					end else if (busy_q) begin
						dc_q <= dc_q - 1'b1;
						if (dc_q == DCW'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end

			// remainder datapath
			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= '0;
					sh_q  <= PADW'(key);
				end else if (busy_q) begin
					rem_q <= rem_next;
					sh_q  <= sh_q << MOD_DIGIT_W;
				end
			end

			assign done   = done_q;
			assign bucket = BW'(rem_q);
		end
	endgenerate

endmodule

FILE: design/chained_hash_map_find_or_insert_top.sv
// ----------------------------------------------------------------------------
// chained_hash_map_find_or_insert_top
// key/value table with separate chaining: find the key, insert on a miss,
// optionally write the value, and report value, flags and entry count
// ----------------------------------------------------------------------------
//  channel  modport  payload    role
//  req      sink     chm_req_t  action, lookup_key, write_data
//  rsp      source   chm_rsp_t  read_value, inserted, table_full, entry_count,
//                               is_empty
//
// one item at a time: an accept step, the bucket hash (a registered mask for a
// power-of-two BUCKETS, otherwise the digit remainder loop), a head read, one
// node memory read per chain node visited, and a miss step when the key is absent
// after reset a clearing pass empties all BUCKETS bucket heads before the
// first item is taken
// a new item is taken while the last result waits in the output register;
// the next result holds until that register is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_map_find_or_insert_top
	import chm_pkg::*;
#(
	parameter int BUCKETS    = 16,
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	chm_stream_if.sink   req,
	chm_stream_if.source rsp
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = LW;

	chm_state_t st_q;

	logic                  act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] data_q;
	logic [BW-1:0]         bkt_q;
	logic [LW-1:0]         head_link_q;
	logic [IW-1:0]         cur_idx_q;
	logic [CW-1:0]         cnt_q;
	logic [BW-1:0]         clr_q;

	logic     rsp_valid_q;
	chm_rsp_t rsp_data_q;

	// memories and their registered read data
	logic [LW-1:0]         head_mem [BUCKETS];
	logic [KEY_BITS-1:0]   nkey_mem [CAPACITY];
	logic [VALUE_BITS-1:0] nval_mem [CAPACITY];
	logic [LW-1:0]         nnext_mem [CAPACITY];
	logic [LW-1:0]         head_rd_q;
	logic [KEY_BITS-1:0]   nkey_rd_q;
	logic [VALUE_BITS-1:0] nval_rd_q;
	logic [LW-1:0]         nnext_rd_q;

	logic [63:0]           key_wide;
	logic [63:0]           data_wide;
	logic [KEY_BITS-1:0]   key_in;
	logic [VALUE_BITS-1:0] data_in;
	logic                  req_fire;
	logic                  slot_free;
	logic                  mod_done;
	logic [BW-1:0]         mod_bucket;

	logic                  head_rd_en;
	logic [BW-1:0]         head_rd_addr;
	logic                  head_wr_en;
	logic [BW-1:0]         head_wr_addr;
	logic [LW-1:0]         head_wr_data;
	logic                  node_rd_en;
	logic [IW-1:0]         node_rd_idx;
	logic                  key_match;
	logic                  hit_done;
	logic                  miss_done;
	logic                  pool_full;
	logic                  do_insert;
	logic [IW-1:0]         alloc_idx;
	logic [LW-1:0]         alloc_link;
	logic                  val_wr_en;
	logic [IW-1:0]         val_wr_idx;
	logic [VALUE_BITS-1:0] val_wr_data;
	logic [CW-1:0]         cnt_after;
	logic [63:0]           cnt_wide;
	logic [VALUE_BITS-1:0] res_value;
	logic [63:0]           res_value_wide;
	chm_rsp_t              res;

	function automatic logic [IW-1:0] link_to_idx(input logic [LW-1:0] link);
		return IW'(link - LW'(1));
	endfunction

	// key and data reduced to the stored widths
	assign key_wide  = 64'(req.data.lookup_key);
	assign data_wide = 64'(req.data.write_data);
	assign key_in    = key_wide[KEY_BITS-1:0];
	assign data_in   = data_wide[VALUE_BITS-1:0];

	assign req.ready = (st_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;

	chm_bucket_mod #(
		.BUCKETS  (BUCKETS),
		.KEY_BITS (KEY_BITS),
		.BW       (BW)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req_fire),
		.key    (key_in),
		.done   (mod_done),
		.bucket (mod_bucket)
	);

	// chain walk decisions
	assign key_match = (st_q == ST_NODE) && (nkey_rd_q == key_q);
	assign hit_done  = key_match && slot_free;
	assign miss_done = (st_q == ST_MISS) && slot_free;
	assign pool_full = (cnt_q == CW'(CAPACITY));
	assign do_insert = miss_done && !pool_full;
	assign alloc_idx  = IW'(cnt_q);
	assign alloc_link = LW'({1'b0, cnt_q} + 1'b1);

	// read port control
	always_comb begin
		head_rd_en   = (st_q == ST_HASH) && mod_done;
		head_rd_addr = mod_bucket;
		node_rd_en   = 1'b0;
		node_rd_idx  = link_to_idx(head_rd_q);
		if ((st_q == ST_HEAD) && (head_rd_q != '0)) begin
			node_rd_en = 1'b1;
		end else if ((st_q == ST_NODE) && !key_match && (nnext_rd_q != '0)) begin
			node_rd_en  = 1'b1;
			node_rd_idx = link_to_idx(nnext_rd_q);
		end
	end

	// write port control
	always_comb begin
		head_wr_en   = 1'b0;
		head_wr_addr = bkt_q;
		head_wr_data = alloc_link;
		if (st_q == ST_CLEAR) begin
			head_wr_en   = 1'b1;
			head_wr_addr = clr_q;
			head_wr_data = '0;
		end else if (do_insert) begin
			head_wr_en = 1'b1;
		end
		val_wr_en   = 1'b0;
		val_wr_idx  = alloc_idx;
		val_wr_data = (act_q == ACT_WRITE) ? data_q : '0;
		if (do_insert) begin
			val_wr_en = 1'b1;
		end else if (hit_done && (act_q == ACT_WRITE)) begin
			val_wr_en  = 1'b1;
			val_wr_idx = cur_idx_q;
		end
	end

	// bucket head memory
	always_ff @(posedge clk) begin
		if (head_wr_en) begin
			head_mem[head_wr_addr] <= head_wr_data;
		end
		if (head_rd_en) begin
			head_rd_q <= head_mem[head_rd_addr];
		end
	end

	// node memories
	always_ff @(posedge clk) begin
		if (do_insert) begin
			nkey_mem[alloc_idx]  <= key_q;
			nnext_mem[alloc_idx] <= head_link_q;
		end
		if (val_wr_en) begin
			nval_mem[val_wr_idx] <= val_wr_data;
		end
		if (node_rd_en) begin
			nkey_rd_q  <= nkey_mem[node_rd_idx];
			nval_rd_q  <= nval_mem[node_rd_idx];
			nnext_rd_q <= nnext_mem[node_rd_idx];
		end
	end

	// result assembly
	always_comb begin
		cnt_after = do_insert ? CW'({1'b0, cnt_q} + 1'b1) : cnt_q;
		if (st_q == ST_NODE) begin
			res_value = (act_q == ACT_WRITE) ? data_q : nval_rd_q;
		end else begin
			res_value = (do_insert && (act_q == ACT_WRITE)) ? data_q : '0;
		end
	end

	assign cnt_wide       = 64'(cnt_after);
	assign res_value_wide = 64'(res_value);

	always_comb begin
		res.read_value  = res_value_wide[VALUE_FIELD_W-1:0];
		res.inserted    = do_insert;
		res.table_full  = miss_done && pool_full;
		res.entry_count = cnt_wide[COUNT_FIELD_W-1:0];
		res.is_empty    = (cnt_after == '0);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_insert) begin
				cnt_q <= cnt_after;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						st_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (mod_done) begin
						st_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					st_q <= (head_rd_q == '0) ? ST_MISS : ST_NODE;
				end
				ST_NODE: begin
					if (key_match) begin
						if (slot_free) begin
							st_q <= ST_IDLE;
						end
					end else if (nnext_rd_q == '0) begin
						st_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					if (slot_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// item context and chain position
	always_ff @(posedge clk) begin
		if (req_fire) begin
			act_q  <= req.data.action;
			key_q  <= key_in;
			data_q <= data_in;
		end
		if (head_rd_en) begin
			bkt_q <= mod_bucket;
		end
		if (st_q == ST_HEAD) begin
			head_link_q <= head_rd_q;
		end
		if (node_rd_en) begin
			cur_idx_q <= node_rd_idx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (hit_done || miss_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_done || miss_done) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// checks
	`include "chained_hash_map_find_or_insert_top_assert.svh"

	`CHM_ASSERT_IMP(a_flags_excl, clk, arst_n, rsp.valid, !(rsp.data.inserted && rsp.data.table_full))
	`CHM_ASSERT_NXT(a_cnt_step, clk, arst_n, do_insert, cnt_q == $past(cnt_q) + 1'b1)
	`CHM_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(CAPACITY))
	`CHM_ASSERT_IMP(a_node_alloc, clk, arst_n, st_q == ST_NODE, cur_idx_q < cnt_q)

endmodule
